>>> design/skvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_pkg - shared types and constants
// Field widths, status codes, sequencer states and the structs passed
// between the sorted key/value table modules.
// ----------------------------------------------------------------------------
package skvt_pkg;

    localparam int KEY_W        = 32;
    localparam int VAL_W        = 64;
    localparam int STATUS_W     = 3;
    localparam int DEF_CAPACITY = 64;

    // stream word layouts
    localparam int IN_TDATA_W  = 96;  // key, value
    localparam int OUT_TDATA_W = 72;  // status, read_value, zero pad

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SET    = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_UPDATED  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_SHIFT,
        S_INS,
        S_DONE
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [VAL_W-1:0]   value;
    } t_result;

    typedef struct packed {
        logic idle;
        logic done;
    } t_seq_stat;

endpackage

>>> design/skvt_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_mem - entry storage
// Single-port-write, single-port-read memory holding {key, value} per entry.
// Read data is registered; contents are undefined until written.
// ----------------------------------------------------------------------------
module skvt_mem #(
    parameter int DEPTH = skvt_pkg::DEF_CAPACITY,
    parameter int WIDTH = skvt_pkg::KEY_W + skvt_pkg::VAL_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/skvt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_seq - search and update sequencer
// Binary search one probe per cycle over the memory, then hit/miss check,
// value overwrite, a full-table drop, or a one-entry-per-cycle shift and insert.
// ----------------------------------------------------------------------------
module skvt_seq #(
    parameter int CAPACITY = skvt_pkg::DEF_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // item from the input side
    input  logic                         i_start,
    input  logic                         i_op,
    input  logic [skvt_pkg::KEY_W-1:0]   i_key,
    input  logic [skvt_pkg::VAL_W-1:0]   i_value,
    // result hand-off
    input  logic                         i_res_ready,
    output skvt_pkg::t_seq_stat          o_stat,
    output skvt_pkg::t_result            o_result,
    // memory port
    output logic                         o_mem_we,
    output logic [$clog2(CAPACITY)-1:0]  o_mem_waddr,
    output logic [skvt_pkg::KEY_W+skvt_pkg::VAL_W-1:0] o_mem_wdata,
    output logic [$clog2(CAPACITY)-1:0]  o_mem_raddr,
    input  logic [skvt_pkg::KEY_W+skvt_pkg::VAL_W-1:0] i_mem_rdata
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = skvt_pkg::KEY_W;
    localparam int VW = skvt_pkg::VAL_W;

    skvt_pkg::t_state  r_state, n_state;
    logic              r_op, n_op;
    logic [KW-1:0]     r_key, n_key;
    logic [VW-1:0]     r_val, n_val;
    logic [CW-1:0]     r_lo, n_lo;
    logic [CW-1:0]     r_hi, n_hi;
    logic [CW-1:0]     r_mid, n_mid;
    logic              r_pend, n_pend;
    logic [CW-1:0]     r_pos, n_pos;
    logic              r_chk_ok, n_chk_ok;
    logic [AW-1:0]     r_widx, n_widx;
    logic [CW-1:0]     r_count, n_count;
    skvt_pkg::t_status r_status, n_status;
    logic [VW-1:0]     r_rval, n_rval;

    logic [KW-1:0]     rd_key;
    logic [VW-1:0]     rd_val;
    logic [CW-1:0]     s_lo, s_hi, s_mid;
    logic              found;

    assign rd_key = i_mem_rdata[KW+VW-1:VW];
    assign rd_val = i_mem_rdata[VW-1:0];
    assign found  = r_chk_ok && (rd_key == r_key);

    // shared compare / midpoint unit: folds in the probe read last cycle
    always_comb begin
        s_lo = r_lo;
        s_hi = r_hi;
        if (r_pend) begin
            if (rd_key < r_key) begin
                s_lo = CW'(r_mid + CW'(1));
            end else begin
                s_hi = r_mid;
            end
        end
        s_mid = CW'(s_lo + ((s_hi - s_lo) >> 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvt_pkg::S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_pos    <= n_pos;
        r_chk_ok <= n_chk_ok;
        r_widx   <= n_widx;
        r_status <= n_status;
        r_rval   <= n_rval;
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pend      = r_pend;
        n_pos       = r_pos;
        n_chk_ok    = r_chk_ok;
        n_widx      = r_widx;
        n_count     = r_count;
        n_status    = r_status;
        n_rval      = r_rval;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pos[AW-1:0];
        o_mem_wdata = {r_key, r_val};
        o_mem_raddr = s_mid[AW-1:0];

        case (r_state)
            skvt_pkg::S_IDLE: begin
                if (i_start) begin
                    n_op    = i_op;
                    n_key   = i_key;
                    n_val   = i_value;
                    n_lo    = '0;
                    n_hi    = r_count;
                    n_pend  = 1'b0;
                    n_state = skvt_pkg::S_SEARCH;
                end
            end
            skvt_pkg::S_SEARCH: begin
                n_lo = s_lo;
                n_hi = s_hi;
                if (s_lo < s_hi) begin
                    o_mem_raddr = s_mid[AW-1:0];
                    n_mid       = s_mid;
                    n_pend      = 1'b1;
                end else begin
                    // lower bound settled; fetch it for the equality check
                    o_mem_raddr = s_lo[AW-1:0];
                    n_pos       = s_lo;
                    n_chk_ok    = s_lo < r_count;
                    n_pend      = 1'b0;
                    n_state     = skvt_pkg::S_CHECK;
                end
            end
            skvt_pkg::S_CHECK: begin
                n_rval = '0;
                if (r_op == skvt_pkg::OP_LOOKUP) begin
                    n_status = found ? skvt_pkg::ST_HIT : skvt_pkg::ST_MISS;
                    n_rval   = found ? rd_val : '0;
                    n_state  = skvt_pkg::S_DONE;
                end else if (found) begin
                    o_mem_we = 1'b1;
                    n_status = skvt_pkg::ST_UPDATED;
                    n_state  = skvt_pkg::S_DONE;
                end else if (r_count == CW'(CAPACITY)) begin
                    n_status = skvt_pkg::ST_FULL;
                    n_state  = skvt_pkg::S_DONE;
                end else if (r_count > r_pos) begin
                    // start moving the tail up, top entry first
                    o_mem_raddr = AW'(r_count - CW'(1));
                    n_widx      = r_count[AW-1:0];
                    n_state     = skvt_pkg::S_SHIFT;
                end else begin
                    n_state = skvt_pkg::S_INS;
                end
            end
            skvt_pkg::S_SHIFT: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_widx;
                o_mem_wdata = i_mem_rdata;
                if (CW'(r_widx) > CW'(r_pos + CW'(1))) begin
                    o_mem_raddr = AW'(r_widx - AW'(2));
                    n_widx      = AW'(r_widx - AW'(1));
                end else begin
                    n_state = skvt_pkg::S_INS;
                end
            end
            skvt_pkg::S_INS: begin
                o_mem_we = 1'b1;
                n_count  = CW'(r_count + CW'(1));
                n_status = skvt_pkg::ST_INSERTED;
                n_rval   = '0;
                n_state  = skvt_pkg::S_DONE;
            end
            skvt_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = skvt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = skvt_pkg::S_IDLE;
            end
        endcase
    end

    assign o_stat.idle     = (r_state == skvt_pkg::S_IDLE);
    assign o_stat.done     = (r_state == skvt_pkg::S_DONE);
    assign o_result.status = r_status;
    assign o_result.value  = r_rval;

    // fill level never passes capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // count only ever grows by one entry
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> (r_count == CW'($past(r_count) + CW'(1))))
        else $error("entry count moved by other than one");

    // search window stays ordered
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::S_SEARCH && !r_pend) |-> (r_lo <= r_hi))
        else $error("search window inverted");

    // shift pointer stays above the insert point
    a_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::S_SHIFT) |-> (CW'(r_widx) > r_pos))
        else $error("shift pointer at or below insert point");

    // a drop is reported only when the table is full
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == skvt_pkg::S_DONE && r_status == skvt_pkg::ST_FULL)
            |-> (r_count == CW'(CAPACITY)))
        else $error("full status with free entries");

endmodule

>>> design/sorted_key_value_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_top - sorted key/value table with lower-bound lookup
// Holds up to CAPACITY entries sorted by ascending key. Lookup returns the
// value on an exact key match; set overwrites or inserts in order, or reports a full table.
// ----------------------------------------------------------------------------
//  channel     dir  word contents (low bit first)
//  s_axis      in   tdata: key[31:0], value[95:32]; tuser: opcode (0 look up, 1 set)
//  m_axis      out  tdata: status[2:0], read_value[66:3], zero[71:67]
//
//  Timing: the search makes one probe, and a shift moves one entry, per cycle
//  on the single read port of the entry memory. The next input word is taken
//  only once the result has passed to the output register.
//  Reset: i_rst_n synchronous, active low; empties the table by clearing the count,
//  no clearing pass (data of entries beyond the count is never used).
//  Stalls: a new word is taken while the previous result still waits in the
//  output register; the sequencer holds its result until that register frees.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top #(
    parameter int CAPACITY = skvt_pkg::DEF_CAPACITY
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input words
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [skvt_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,  // key, value
    input  logic                              i_s_axis_tuser,  // opcode
    // result words
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [skvt_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata   // status, read_value, pad
);

    localparam int AW = $clog2(CAPACITY);
    localparam int KW = skvt_pkg::KEY_W;
    localparam int VW = skvt_pkg::VAL_W;
    localparam int MW = KW + VW;
    localparam int RW = skvt_pkg::STATUS_W + VW;

    skvt_pkg::t_seq_stat seq_stat;
    skvt_pkg::t_result   seq_result;

    logic          start;
    logic          res_ready;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic [MW-1:0] mem_wdata;
    logic [MW-1:0] mem_rdata;

    // output register
    logic              r_out_valid;
    skvt_pkg::t_result r_out_data;

    assign o_s_axis_tready = seq_stat.idle;
    assign start           = i_s_axis_tvalid && seq_stat.idle;
    // sequencer may hand over when the slot is empty or being drained
    assign res_ready       = !r_out_valid || i_m_axis_tready;

    skvt_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_op        (i_s_axis_tuser),
        .i_key       (i_s_axis_tdata[KW-1:0]),
        .i_value     (i_s_axis_tdata[MW-1:KW]),
        .i_res_ready (res_ready),
        .o_stat      (seq_stat),
        .o_result    (seq_result),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    skvt_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (MW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (seq_stat.done && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_stat.done && res_ready) begin
            r_out_data <= seq_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(skvt_pkg::OUT_TDATA_W - RW){1'b0}},
                              r_out_data.value, r_out_data.status};

endmodule
